### sv/plqm_pkg.sv
// Shared constants, types and helpers for the pooled linked queue manager.
package plqm_pkg;

    localparam int NODE_COUNT   = 64;
    localparam int QUEUE_COUNT  = 4;
    localparam int PAYLOAD_BITS = 32;

    localparam int NODE_AW = $clog2(NODE_COUNT);
    localparam int LINK_W  = $clog2(NODE_COUNT + 1);
    localparam int QID_W   = 2;
    localparam int CNT_W   = $clog2(NODE_COUNT + 1);

    typedef logic [NODE_AW-1:0]      t_node;
    typedef logic [LINK_W-1:0]       t_link;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;

    localparam t_link NULL_LINK = t_link'(NODE_COUNT);

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOFREE = 2'd1,
        STAT_EMPTY  = 2'd2
    } t_status;

    typedef enum logic {
        REQ_APPEND = 1'b0,
        REQ_POP    = 1'b1
    } t_req;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Write request into the link memory.
    typedef struct packed {
        logic  en;
        t_node addr;
        t_link data;
    } t_link_wr;

    // Write request into the payload memory.
    typedef struct packed {
        logic     en;
        t_node    addr;
        t_payload data;
    } t_pay_wr;

    // Link of a node that has not been written since reset.
    function automatic t_link link_reset_value(input t_node node);
        t_link val;
        if (node == '0) begin
            val = NULL_LINK;
        end else begin
            val = t_link'(node) - t_link'(1);
        end
        return val;
    endfunction

endpackage

### sv/pooled_linked_queue_manager.sv
// Top level: several FIFO queues sharing one pool of linked nodes with a LIFO free list.
// Operation: the node read is issued as a request is accepted, and the pointer update
// with the memory writes follows in the exec state; busy is high there, so no new
// request is taken before the last is through. The result strobe is high in the cycle
// after execution, and the receiver cannot stall.
// Reset (synchronous, active low) empties all queues and restores the free list at once.
module pooled_linked_queue_manager (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_req_type,
    input  logic [plqm_pkg::QID_W-1:0]     i_queue_id,
    input  logic [31:0]                    i_data_in,
    output logic                           o_strobe,
    output logic [1:0]                     o_status,
    output logic [31:0]                    o_data_out,
    output logic [plqm_pkg::CNT_W-1:0]     o_queue_length
);
    import plqm_pkg::*;

    // Control state: idle waits for a request, exec applies it.
    t_state r_state;
    t_state n_state;

    // Request register, loaded when a request is accepted.
    logic              r_req_type;
    logic [QID_W-1:0]  r_queue_id;
    t_payload          r_data_in;

    // List pointers.
    t_link  r_free_head;
    t_link  n_free_head;
    t_node  r_q_head [QUEUE_COUNT];
    t_node  r_q_tail [QUEUE_COUNT];
    t_count r_q_cnt  [QUEUE_COUNT];
    t_node  n_head;
    t_node  n_tail;
    t_count n_cnt;
    logic   q_upd;

    // Result register.
    logic     r_strobe;
    t_status  r_status;
    t_payload r_data_out;
    t_count   r_queue_length;
    t_status  n_status;
    t_payload n_data_out;
    t_count   n_queue_length;

    logic     accept;
    logic     exec;
    t_node    rd_addr;
    t_link    link_rd;
    t_payload pay_rd;
    t_link_wr link_wr;
    t_pay_wr  pay_wr;

    logic   q_ok;
    t_node  cur_head;
    t_node  cur_tail;
    t_count cur_cnt;

    assign accept = start && !busy;

    // The memory read is issued as the request is accepted: a pop reads the
    // queue's head node, an append reads the node at the free-list head.
    always_comb begin
        if (i_req_type == REQ_POP) begin
            rd_addr = r_q_head[i_queue_id];
        end else begin
            rd_addr = r_free_head[NODE_AW-1:0];
        end
    end

    plqm_node_pool u_pool (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_link_wr (link_wr),
        .i_pay_wr  (pay_wr),
        .o_link_rd (link_rd),
        .o_pay_rd  (pay_rd)
    );

    // Next-state logic.
    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Output decode of the state.
    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                exec = 1'b0;
            end
            ST_EXEC: begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default: begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    assign q_ok     = (32'(r_queue_id) < QUEUE_COUNT);
    assign cur_head = r_q_head[r_queue_id];
    assign cur_tail = r_q_tail[r_queue_id];
    assign cur_cnt  = r_q_cnt[r_queue_id];

    // One pass over the request. The link of a queue's tail is never used
    // while it is the tail, so an append only writes the old tail's link;
    // this keeps the link memory at one write per request.
    always_comb begin
        n_free_head    = r_free_head;
        n_head         = cur_head;
        n_tail         = cur_tail;
        n_cnt          = cur_cnt;
        q_upd          = 1'b0;
        n_status       = STAT_OK;
        n_data_out     = '0;
        n_queue_length = '0;
        link_wr        = '0;
        pay_wr         = '0;

        if (!q_ok) begin
            n_status = STAT_EMPTY;
        end else if (r_req_type == REQ_APPEND) begin
            if (r_free_head == NULL_LINK) begin
                n_status       = STAT_NOFREE;
                n_queue_length = cur_cnt;
            end else begin
                n_free_head = link_rd;
                pay_wr.en   = exec;
                pay_wr.addr = r_free_head[NODE_AW-1:0];
                pay_wr.data = r_data_in;
                if (cur_cnt == '0) begin
                    n_head = r_free_head[NODE_AW-1:0];
                end else begin
                    link_wr.en   = exec;
                    link_wr.addr = cur_tail;
                    link_wr.data = r_free_head;
                end
                n_tail         = r_free_head[NODE_AW-1:0];
                n_cnt          = cur_cnt + t_count'(1);
                q_upd          = 1'b1;
                n_queue_length = n_cnt;
            end
        end else begin
            if (cur_cnt == '0) begin
                n_status = STAT_EMPTY;
            end else begin
                n_data_out   = pay_rd;
                link_wr.en   = exec;
                link_wr.addr = cur_head;
                link_wr.data = r_free_head;
                n_free_head  = t_link'(cur_head);
                q_upd        = 1'b1;
                if (cur_cnt == t_count'(1) || link_rd == NULL_LINK) begin
                    n_cnt  = '0;
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    n_cnt  = cur_cnt - t_count'(1);
                    n_head = link_rd[NODE_AW-1:0];
                end
                n_queue_length = n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_strobe    <= 1'b0;
            r_free_head <= t_link'(NODE_COUNT - 1);
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                r_q_head[i] <= '0;
                r_q_tail[i] <= '0;
                r_q_cnt[i]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= exec;
            if (exec) begin
                r_free_head <= n_free_head;
                if (q_upd) begin
                    r_q_head[r_queue_id] <= n_head;
                    r_q_tail[r_queue_id] <= n_tail;
                    r_q_cnt[r_queue_id]  <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req_type;
            r_queue_id <= i_queue_id;
            r_data_in  <= i_data_in;
        end
        if (exec) begin
            r_status       <= n_status;
            r_data_out     <= n_data_out;
            r_queue_length <= n_queue_length;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_data_out     = r_data_out;
    assign o_queue_length = r_queue_length;

`ifndef NO_ASSERTIONS
    // Every request that enters execution produces exactly one result next cycle.
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> o_strobe)
        else $error("request in execution produced no result");

    // A result never appears without an earlier accepted request.
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 2))
        else $error("result without an accepted request");

    // The free-list head is a node index or the null link, never beyond.
    a_free_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= NULL_LINK)
        else $error("free-list head out of range");

    // A successful pop reports one entry fewer than the queue held.
    a_pop_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && q_ok && r_req_type == REQ_POP && cur_cnt != '0)
            |=> (o_queue_length == $past(cur_cnt) - t_count'(1)))
        else $error("pop reported a wrong queue length");
`endif

endmodule

### sv/plqm_node_pool.sv
// Node pool storage: link memory with per-entry valid bits and payload memory.
module plqm_node_pool (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  plqm_pkg::t_node     i_rd_addr,
    input  plqm_pkg::t_link_wr  i_link_wr,
    input  plqm_pkg::t_pay_wr   i_pay_wr,
    output plqm_pkg::t_link     o_link_rd,
    output plqm_pkg::t_payload  o_pay_rd
);
    import plqm_pkg::*;

    t_link    r_link_mem [NODE_COUNT];
    t_payload r_pay_mem  [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_link_vld;

    t_link    r_link_rd;
    logic     r_link_rd_vld;
    t_node    r_rd_addr;
    t_payload r_pay_rd;

    // Valid bits stand in for the reset pattern of the link memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
        end else if (i_link_wr.en) begin
            r_link_vld[i_link_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_link_wr.en) begin
            r_link_mem[i_link_wr.addr] <= i_link_wr.data;
        end
        if (i_pay_wr.en) begin
            r_pay_mem[i_pay_wr.addr] <= i_pay_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_link_rd     <= r_link_mem[i_rd_addr];
            r_link_rd_vld <= r_link_vld[i_rd_addr];
            r_rd_addr     <= i_rd_addr;
            r_pay_rd      <= r_pay_mem[i_rd_addr];
        end
    end

    assign o_link_rd = r_link_rd_vld ? r_link_rd : link_reset_value(r_rd_addr);
    assign o_pay_rd  = r_pay_rd;

endmodule

### bench/queue_pool_checker.sv
// Checker that predicts every reply of the pooled linked queue manager and compares it.
module queue_pool_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic                           i_req_type,
    input  logic [plqm_pkg::QID_W-1:0]     i_queue_id,
    input  logic [31:0]                    i_data_in,
    input  logic                           i_strobe,
    input  logic [1:0]                     i_status,
    input  logic [31:0]                    i_data_out,
    input  logic [plqm_pkg::CNT_W-1:0]     i_queue_length,
    output int                             o_mismatches,
    output int                             o_outstanding
);
    import plqm_pkg::*;

    typedef struct {
        t_status  status;
        t_payload word;
        t_count   length;
    } t_reply;

    t_link    link_of  [NODE_COUNT];
    t_payload word_of  [NODE_COUNT];
    t_link    free_top;
    t_node    first_of [QUEUE_COUNT];
    t_node    last_of  [QUEUE_COUNT];
    t_count   depth_of [QUEUE_COUNT];
    t_reply   replies_due [$];
    t_reply   want;
    int       mismatch_total = 0;
    int       due_total = 0;

    assign o_mismatches  = mismatch_total;
    assign o_outstanding = due_total;

    // Free list runs from the highest node down to node 0; every queue is empty.
    function automatic void clear_pool();
        for (int n = 0; n < NODE_COUNT; n++) begin
            link_of[n] = (n == 0) ? NULL_LINK : t_link'(n - 1);
            word_of[n] = '0;
        end
        free_top = t_link'(NODE_COUNT - 1);
        for (int q = 0; q < QUEUE_COUNT; q++) begin
            first_of[q] = '0;
            last_of[q]  = '0;
            depth_of[q] = '0;
        end
    endfunction

    function automatic t_reply serve_request(t_req kind, logic [QID_W-1:0] qid,
                                             t_payload word);
        t_reply r;
        t_node  node;
        t_link  nxt;
        r.status = STAT_OK;
        r.word   = '0;
        r.length = '0;
        if (int'(qid) >= QUEUE_COUNT) begin
            r.status = STAT_EMPTY;
        end else if (kind == REQ_APPEND) begin
            if (free_top >= NULL_LINK) begin
                r.status = STAT_NOFREE;
            end else begin
                node          = t_node'(free_top);
                free_top      = link_of[node];
                word_of[node] = word;
                link_of[node] = NULL_LINK;
                if (depth_of[qid] == '0) begin
                    first_of[qid] = node;
                end else begin
                    link_of[last_of[qid]] = t_link'(node);
                end
                last_of[qid]  = node;
                depth_of[qid] = depth_of[qid] + t_count'(1);
            end
            r.length = depth_of[qid];
        end else if (depth_of[qid] == '0) begin
            r.status = STAT_EMPTY;
        end else begin
            node          = first_of[qid];
            r.word        = word_of[node];
            nxt           = link_of[node];
            link_of[node] = free_top;
            free_top      = t_link'(node);
            depth_of[qid] = depth_of[qid] - t_count'(1);
            if (depth_of[qid] == '0 || nxt >= NULL_LINK) begin
                depth_of[qid] = '0;
                first_of[qid] = '0;
                last_of[qid]  = '0;
            end else begin
                first_of[qid] = t_node'(nxt);
            end
            r.length = depth_of[qid];
        end
        return r;
    endfunction

    task automatic report_mismatch(bit have_want, t_reply exp_reply);
        mismatch_total++;
        if (mismatch_total <= 10) begin
            if (have_want) begin
                $display("%0t: reply mismatch: expected status %s data %h length %0d",
                         $time, exp_reply.status.name(), exp_reply.word, exp_reply.length);
                $display("    got status %0d data %h length %0d",
                         i_status, i_data_out, i_queue_length);
            end else begin
                $display("%0t: reply with no request outstanding: status %0d data %h len %0d",
                         $time, i_status, i_data_out, i_queue_length);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_pool();
            replies_due.delete();
        end else begin
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                replies_due.push_back(serve_request(t_req'(i_req_type), i_queue_id,
                                                    t_payload'(i_data_in)));
            end
            if (i_strobe === 1'b1) begin
                if (replies_due.size() == 0) begin
                    report_mismatch(1'b0, want);
                end else begin
                    want = replies_due.pop_front();
                    if (i_status !== want.status || i_data_out !== want.word ||
                        i_queue_length !== want.length) begin
                        report_mismatch(1'b1, want);
                    end
                end
            end
        end
        due_total = replies_due.size();
    end

endmodule

### bench/tb_pooled_linked_queue_manager.sv
// Testbench top for the pooled linked queue manager: stimulus, watchdog and verdict.
module tb_pooled_linked_queue_manager;
    import plqm_pkg::*;

    // A correct run never goes this long without a request or a reply moving.
    localparam int IDLE_LIMIT    = 2000;
    localparam int SEGMENTS      = 14;
    localparam int SEGMENT_ITEMS = 115;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_req_type;
    logic [QID_W-1:0]   i_queue_id;
    logic [31:0]        i_data_in;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [31:0]        o_data_out;
    logic [CNT_W-1:0]   o_queue_length;

    int mismatches;
    int outstanding;
    int idle_cycles;
    bit idle_gaps;

    pooled_linked_queue_manager i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_queue_id     (i_queue_id),
        .i_data_in      (i_data_in),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_data_out     (o_data_out),
        .o_queue_length (o_queue_length)
    );

    queue_pool_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_req_type     (i_req_type),
        .i_queue_id     (i_queue_id),
        .i_data_in      (i_data_in),
        .i_strobe       (o_strobe),
        .i_status       (o_status),
        .i_data_out     (o_data_out),
        .i_queue_length (o_queue_length),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The watchdog restarts whenever a request is accepted or a reply appears.
    // If the block hangs or drops a reply, the count runs out and the run fails.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request and holds it until the block takes it. When gaps are
    // enabled, start drops for a random number of cycles before the request, so
    // gaps land on both the idle and the exec phase of the block's operation. With no gap,
    // start stays high and only the fields change at the falling edge.
    task automatic issue_request(t_req kind, logic [QID_W-1:0] qid, logic [31:0] word);
        int gap;
        gap = idle_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_req_type <= kind;
        i_queue_id <= qid;
        i_data_in  <= word;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Stops sending and waits until every reply still in flight has been checked.
    task automatic wait_for_drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    initial begin
        int          append_weight [4];
        int          favored;
        t_req        kind;
        logic [QID_W-1:0] qid;
        logic [31:0] word;

        // Append bias per segment: draining, balanced, filling, and flooding the
        // pool so that appends run into the no-free-node case many times over.
        append_weight = '{15, 50, 85, 97};

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_req_type <= REQ_APPEND;
        i_queue_id <= '0;
        i_data_in  <= '0;
        idle_gaps  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Pops on empty queues first, then appends with extreme and
        // alternating payloads on every queue, then pops that drain each queue
        // back to empty so the freed nodes return to the free list.
        for (int q = 0; q < QUEUE_COUNT; q++) begin
            issue_request(REQ_POP, q[QID_W-1:0], 32'hFFFF_FFFF);
        end
        issue_request(REQ_APPEND, 2'd0, 32'h0000_0000);
        issue_request(REQ_APPEND, 2'd0, 32'hFFFF_FFFF);
        issue_request(REQ_APPEND, 2'd1, 32'hA5A5_A5A5);
        issue_request(REQ_APPEND, 2'd2, 32'h5A5A_5A5A);
        issue_request(REQ_APPEND, 2'd3, 32'h8000_0001);
        issue_request(REQ_APPEND, 2'd3, 32'h7FFF_FFFE);
        issue_request(REQ_POP,    2'd0, 32'h0);
        issue_request(REQ_POP,    2'd0, 32'h0);
        issue_request(REQ_POP,    2'd0, 32'h0);
        issue_request(REQ_APPEND, 2'd1, 32'h1234_5678);
        issue_request(REQ_POP,    2'd1, 32'h0);
        issue_request(REQ_POP,    2'd1, 32'h0);
        issue_request(REQ_POP,    2'd1, 32'h0);
        issue_request(REQ_POP,    2'd3, 32'h0);
        issue_request(REQ_POP,    2'd3, 32'h0);
        issue_request(REQ_POP,    2'd2, 32'h0);
        wait_for_drain();

        // Random part in segments. Each segment picks its append bias, whether
        // the sender idles, and sometimes a favored queue that takes most of the
        // traffic so that one queue grows long. Every segment ends with a full
        // drain of the replies in flight.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            idle_gaps = ($urandom_range(0, 3) != 0);
            favored   = $urandom_range(0, 7);
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                kind = ($urandom_range(0, 99) < append_weight[seg % 4]) ? REQ_APPEND : REQ_POP;
                if (favored < QUEUE_COUNT && $urandom_range(0, 3) != 0) begin
                    qid = favored[QID_W-1:0];
                end else begin
                    qid = QID_W'($urandom_range(0, QUEUE_COUNT - 1));
                end
                case ($urandom_range(0, 15))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = $urandom;
                endcase
                issue_request(kind, qid, word);
            end
            wait_for_drain();
        end

        // Give the block a few more cycles in case a stray reply follows.
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
